// ===== hw/rtl/fba_pkg.sv =====
// Shared definitions for the frame bitmap allocator.
// Operation codes, field widths and word-mask helpers; no dependencies.
package fba_pkg;

   // Operation codes carried on the request channel's tuser
   localparam logic [2:0] OP_ALLOC     = 3'd0;
   localparam logic [2:0] OP_ALLOC_LOW = 3'd1;
   localparam logic [2:0] OP_FREE      = 3'd2;
   localparam logic [2:0] OP_RESERVE   = 3'd3;
   localparam logic [2:0] OP_RELEASE   = 3'd4;
   localparam logic [2:0] OP_TEST      = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] REG_FRAMES_IN_USE = 2'd0;
   localparam logic [1:0] REG_LOW_LIMIT     = 2'd1;
   localparam logic [1:0] REG_SKIP_START    = 2'd2;
   localparam logic [1:0] REG_SKIP_END      = 2'd3;

   localparam int OP_W    = 3;
   localparam int FRAME_W = 20;   // frame number field
   localparam int REG_W   = 17;   // configuration registers
   localparam int RES_W   = 16;   // granted frame field
   localparam int WORD_W  = 64;   // bitmap word
   localparam int BIT_W   = 6;    // bit index inside a word

   // Bits of word w whose frame number lies below x
   function automatic logic [WORD_W-1:0] lt_mask(logic [FRAME_W:0] x,
                                                 logic [FRAME_W-BIT_W:0] w);
      logic [FRAME_W-BIT_W:0] hi;
      hi = x[FRAME_W:BIT_W];
      if (hi > w) begin
         lt_mask = '1;
      end else if (hi == w) begin
         lt_mask = (WORD_W'(1) << x[BIT_W-1:0]) - WORD_W'(1);
      end else begin
         lt_mask = '0;
      end
   endfunction

   // Index of the lowest set bit, binary search in six halving steps
   function automatic logic [BIT_W-1:0] lowest_set(logic [WORD_W-1:0] m);
      logic [WORD_W-1:0] v;
      logic [BIT_W-1:0]  idx;
      v   = m;
      idx = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         if ((v & ((WORD_W'(1) << (1 << k)) - WORD_W'(1))) == '0) begin
            v      = v >> (1 << k);
            idx[k] = 1'b1;
         end
      end
      lowest_set = idx;
   endfunction

endpackage

// ===== hw/rtl/frame_bitmap_allocator_top.sv =====
// Frame bitmap allocator top level: control, configuration and response register.
// Depends on fba_pkg and fba_word_ram.
//
// Usage:
//   req_* carries one item: the operation on tuser, the frame number on tdata.
//   rsp_* returns exactly one item per request: granted frame, ok and used flag.
//   csr_* writes the four configuration registers; write only while idle.
// Sequencing:
//   One request is in flight at a time. Free, reserve, release and test do one
//   memory read, then the write-back (test writes nothing). Alloc and alloc_low
//   scan the bitmap one 64-frame word per cycle through the single memory read
//   port; at least one word and at most ceil(bound / 64) words, bound = frame limit.
// Reset:
//   A clearing pass marks every frame used, one word per cycle over all
//   ceil(NUM_FRAMES / 64) words; req_tready stays low during it.
// Stalls:
//   A finished response waits in the output register; a new request is taken
//   once the block is idle, and a finishing request holds (without touching
//   the bitmap) until the output register is free.
module frame_bitmap_allocator_top
   import fba_pkg::*;
#(
   parameter int NUM_FRAMES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] frame, zero padded
   input  logic [2:0]  req_tuser,   // [2:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] result_frame, [16] ok, [17] used, zero padded
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam int WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BW    = FRAME_W + 1;          // frame bound width
   localparam int WXW   = FRAME_W - BIT_W + 1;  // widened word index

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [REG_W-1:0] fiu_ff, low_ff, skip_s_ff, skip_e_ff;

   // current item
   logic [OP_W-1:0]    op_ff, op_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [BW-1:0]      bound_ff, bound_in;
   logic               use_skip_ff, use_skip_in;
   logic [AW-1:0]      scan_w_ff, scan_w_in;
   logic [AW-1:0]      clr_w_ff, clr_w_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   // memory port signals
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   fba_word_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff    <= REG_W'(65536);
         low_ff    <= REG_W'(4096);
         skip_s_ff <= '0;
         skip_e_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRAMES_IN_USE: fiu_ff    <= csr_data;
            REG_LOW_LIMIT:     low_ff    <= csr_data;
            REG_SKIP_START:    skip_s_ff <= csr_data;
            REG_SKIP_END:      skip_e_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Shared terms
   logic [BW-1:0]      num_w, fiu_w, low_w, min_fl;
   logic               out_free, accept, frm_in_store, advance;
   logic [WXW-1:0]     scan_wx;
   logic [WXW:0]       need_words;
   logic               last_word;
   logic [WORD_W-1:0]  skip_mask, cand, bit_m;
   logic [BIT_W-1:0]   hit_bit;
   logic [FRAME_W:0]   hit_frame;

   assign num_w  = BW'(NUM_FRAMES);
   assign fiu_w  = BW'(fiu_ff);
   assign low_w  = BW'(low_ff);
   assign min_fl = (fiu_w < low_w) ? fiu_w : low_w;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign frm_in_store = {1'b0, frame_ff} < num_w;
   assign bit_m        = WORD_W'(1) << frame_ff[BIT_W-1:0];

   // Candidate free bits of the word under scan
   assign scan_wx    = WXW'(scan_w_ff);
   assign skip_mask  = use_skip_ff ?
                       (lt_mask(BW'(skip_e_ff), scan_wx) & ~lt_mask(BW'(skip_s_ff), scan_wx))
                       : '0;
   assign cand       = ~rd_data & lt_mask(bound_ff, scan_wx) & ~skip_mask;
   assign hit_bit    = lowest_set(cand);
   assign hit_frame  = {scan_wx, hit_bit};
   assign need_words = {1'b0, bound_ff[FRAME_W:BIT_W]} + (WXW+1)'(|bound_ff[BIT_W-1:0]);
   assign last_word  = ({1'b0, scan_wx} + (WXW+1)'(1)) >= need_words;
   assign advance    = (cand == '0) && !last_word;

   // Memory read address
   always_comb begin
      case (state_ff)
         ST_IDLE:
            rd_addr = (req_tuser == OP_ALLOC || req_tuser == OP_ALLOC_LOW) ? '0
                      : req_tdata[AW+BIT_W-1:BIT_W];
         ST_READ: rd_addr = frame_ff[AW+BIT_W-1:BIT_W];
         ST_SCAN: rd_addr = advance ? scan_w_ff + AW'(1) : scan_w_ff;
         default: rd_addr = '0;
      endcase
   end

   // Control and write-back
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      frame_in     = frame_ff;
      bound_in     = bound_ff;
      use_skip_in  = use_skip_ff;
      scan_w_in    = scan_w_ff;
      clr_w_in     = clr_w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = frame_ff[AW+BIT_W-1:BIT_W];
      wr_data      = rd_data;

      case (state_ff)
         // mark every frame used after reset
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = clr_w_ff;
            wr_data  = '1;
            clr_w_in = clr_w_ff + AW'(1);
            if (clr_w_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in       = req_tuser;
               frame_in    = req_tdata[FRAME_W-1:0];
               scan_w_in   = '0;
               use_skip_in = (req_tuser == OP_ALLOC_LOW);
               if (req_tuser == OP_ALLOC_LOW) begin
                  bound_in = (min_fl < num_w) ? min_fl : num_w;
               end else begin
                  bound_in = (fiu_w < num_w) ? fiu_w : num_w;
               end
               state_in = (req_tuser == OP_ALLOC || req_tuser == OP_ALLOC_LOW)
                          ? ST_SCAN : ST_READ;
            end
         end

         // single-frame operations
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
               case (op_ff)
                  OP_FREE: begin
                     if (frame_ff != '0 && {1'b0, frame_ff} < fiu_w && frm_in_store) begin
                        wr_en          = 1'b1;
                        wr_data        = rd_data & ~bit_m;
                        rsp_data_in[16] = 1'b1;
                     end
                  end
                  OP_RESERVE: begin
                     if (frm_in_store) begin
                        wr_en          = 1'b1;
                        wr_data        = rd_data | bit_m;
                        rsp_data_in[16] = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     if (frm_in_store) begin
                        wr_en          = 1'b1;
                        wr_data        = rd_data & ~bit_m;
                        rsp_data_in[16] = 1'b1;
                     end
                  end
                  OP_TEST: begin
                     rsp_data_in[16] = frm_in_store;
                     rsp_data_in[17] = !frm_in_store || ((rd_data & bit_m) != '0);
                  end
                  default: ;
               endcase
            end
         end

         // first-fit scan, one word per cycle
         ST_SCAN: begin
            if (advance) begin
               scan_w_in = scan_w_ff + AW'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
               if (cand != '0) begin
                  wr_en                   = 1'b1;
                  wr_addr                 = scan_w_ff;
                  wr_data                 = rd_data | (WORD_W'(1) << hit_bit);
                  rsp_data_in[RES_W-1:0]  = hit_frame[RES_W-1:0];
                  rsp_data_in[16]         = 1'b1;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_w_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_w_ff     <= clr_w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      frame_ff    <= frame_in;
      bound_ff    <= bound_in;
      use_skip_ff <= use_skip_in;
      scan_w_ff   <= scan_w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/fba_word_ram.sv =====
// Bitmap word store: one write port, one read port, registered read data.
// Uses fba_pkg for the word width.
module fba_word_ram
   import fba_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data_ff
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for frame_bitmap_allocator_top: directed and random
// allocator requests, predicted in-bench and checked against every response item.
// Depends on fba_pkg and the frame_bitmap_allocator_top RTL.
`timescale 1ns / 100ps

module tb_top;
   import fba_pkg::*;

   localparam int NUM_FRAMES = 65536;

   // Operation codes the block ignores
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [19:0] frame;
   } frame_req_t;

   typedef struct packed {
      logic        used;
      logic        ok;
      logic [15:0] grant;
   } alloc_rsp_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [19:0] frame, zero padded
   logic [2:0]  req_tuser  = '0;   // [2:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] result_frame, [16] ok, [17] used, zero padded
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [16:0] csr_data   = '0;

   // Shadow of the used bitmap and the configuration registers
   bit          frame_used [NUM_FRAMES] = '{default: 1'b1};
   logic [16:0] cfg_frames_in_use = 17'd65536;
   logic [16:0] cfg_low_limit     = 17'd4096;
   logic [16:0] cfg_skip_start    = 17'd0;
   logic [16:0] cfg_skip_end      = 17'd0;

   frame_req_t  req_queue [$];
   alloc_rsp_t  expected_rsp [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int          accepted_count = 0;
   int          rsp_count      = 0;
   int          mismatch_count = 0;
   int          grant_count    = 0;
   int          refused_count  = 0;
   int          phase_count    = 0;

   frame_bitmap_allocator_top #(
      .NUM_FRAMES(NUM_FRAMES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 200)
         $display("MISMATCH @%0t rsp #%0d: %s", $time, rsp_count, what);
   endtask

   // First-fit over [0, bound), optionally skipping [lo, hi); marks the hit used
   function automatic bit first_fit(input int unsigned bound, input bit skip,
                                    input int unsigned lo, input int unsigned hi,
                                    output int unsigned got);
      int unsigned lim;
      lim = (bound > NUM_FRAMES) ? NUM_FRAMES : bound;
      got = 0;
      for (int unsigned i = 0; i < lim; i++) begin
         if (skip && i >= lo && i < hi)
            continue;
         if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            got = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Expected response item for one request; updates the shadow bitmap
   function automatic alloc_rsp_t predict_op(input logic [2:0] op, input logic [19:0] frame);
      alloc_rsp_t  r;
      int unsigned f, got, bound;
      bit          in_store, hit;
      r        = '0;
      f        = frame;
      in_store = f < NUM_FRAMES;
      hit      = 1'b0;
      case (op)
         OP_ALLOC, OP_ALLOC_LOW: begin
            if (op == OP_ALLOC) begin
               hit = first_fit(cfg_frames_in_use, 1'b0, 0, 0, got);
            end else begin
               bound = (cfg_frames_in_use < cfg_low_limit) ? cfg_frames_in_use
                                                           : cfg_low_limit;
               hit = first_fit(bound, 1'b1, cfg_skip_start, cfg_skip_end, got);
            end
            if (hit) begin
               r.grant = got[15:0];
               r.ok    = 1'b1;
               grant_count++;
            end else begin
               refused_count++;
            end
         end
         OP_FREE: begin
            // frame 0 is the null frame and never freed
            if (f != 0 && f < cfg_frames_in_use && in_store) begin
               frame_used[f] = 1'b0;
               r.ok = 1'b1;
            end
         end
         OP_RESERVE, OP_RELEASE: begin
            if (in_store) begin
               frame_used[f] = (op == OP_RESERVE);
               r.ok = 1'b1;
            end
         end
         OP_TEST: begin
            r.used = !in_store || frame_used[f];
            r.ok   = in_store;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Request driver: presents queued items, idles at random
   always @(posedge clock) begin
      alloc_rsp_t want;
      frame_req_t nxt_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = predict_op(req_tuser, req_tdata[19:0]);
            expected_rsp.push_back(want);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt_req = req_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, nxt_req.frame};
               req_tuser  <= nxt_req.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure, field-by-field compare
   always @(posedge clock) begin
      alloc_rsp_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected item, tdata %h", rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata[15:0] !== want.grant)
                  report_mismatch($sformatf("result_frame %0d, expected %0d",
                                            rsp_tdata[15:0], want.grant));
               if (rsp_tdata[16] !== want.ok)
                  report_mismatch($sformatf("ok %b, expected %b", rsp_tdata[16], want.ok));
               if (rsp_tdata[17] !== want.used)
                  report_mismatch($sformatf("used %b, expected %b", rsp_tdata[17], want.used));
            end
            rsp_count++;
         end
      end
   end

   function automatic void queue_req(input logic [2:0] op, input logic [19:0] frame);
      req_queue.push_back('{op, frame});
   endfunction

   // Random request: frames mostly in the active span, some at the limits,
   // some anywhere in the 20-bit field
   function automatic frame_req_t random_req(input int unsigned span);
      frame_req_t  r;
      int unsigned pick;
      int          near;
      pick = $urandom_range(99);
      if (pick < 22)      r.op = OP_ALLOC;
      else if (pick < 34) r.op = OP_ALLOC_LOW;
      else if (pick < 52) r.op = OP_FREE;
      else if (pick < 57) r.op = OP_RESERVE;
      else if (pick < 77) r.op = OP_RELEASE;
      else if (pick < 96) r.op = OP_TEST;
      else if (pick < 98) r.op = OP_SPARE_A;
      else                r.op = OP_SPARE_B;
      pick = $urandom_range(99);
      if (pick < 75) begin
         r.frame = 20'($urandom_range(span - 1));
      end else if (pick < 85) begin
         case ($urandom_range(6))
            0:       near = 0;
            1:       near = int'(cfg_frames_in_use) - 1;
            2:       near = cfg_frames_in_use;
            3:       near = NUM_FRAMES - 1;
            4:       near = NUM_FRAMES;
            5:       near = cfg_low_limit;
            default: near = cfg_skip_start;
         endcase
         r.frame = 20'(near);
      end else begin
         r.frame = 20'($urandom());
      end
      return r;
   endfunction

   // Waits at a falling edge until no item is queued, in flight or owed
   task automatic wait_drained();
      do @(negedge clock);
      while (req_queue.size() != 0 || req_tvalid || expected_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Register write; called at a rising edge, returns at one
   task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_FRAMES_IN_USE: cfg_frames_in_use = value;
         REG_LOW_LIMIT:     cfg_low_limit     = value;
         REG_SKIP_START:    cfg_skip_start    = value;
         REG_SKIP_END:      cfg_skip_end      = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // One register setting: reconfigure while idle, then two random batches
   // with a full drain between them
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input logic [16:0] frames, input logic [16:0] low,
                            input logic [16:0] skip_lo, input logic [16:0] skip_hi,
                            input int unsigned count, input int unsigned span);
      wait_drained();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      @(posedge clock);
      write_reg(REG_FRAMES_IN_USE, frames);
      write_reg(REG_LOW_LIMIT, low);
      write_reg(REG_SKIP_START, skip_lo);
      write_reg(REG_SKIP_END, skip_hi);
      phase_count++;
      for (int half = 0; half < 2; half++) begin
         @(negedge clock);
         repeat (count / 2) req_queue.push_back(random_req(span));
         wait_drained();
      end
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, all frames used
      @(negedge clock);
      queue_req(OP_ALLOC, 20'd0);          // nothing free anywhere
      queue_req(OP_ALLOC_LOW, 20'd0);
      queue_req(OP_TEST, 20'd0);
      queue_req(OP_TEST, 20'd65535);
      queue_req(OP_TEST, 20'd65536);       // just outside the store
      queue_req(OP_TEST, 20'hFFFFF);
      queue_req(OP_RELEASE, 20'd0);
      queue_req(OP_ALLOC, 20'hFFFFF);      // grants frame zero
      queue_req(OP_FREE, 20'd0);           // null frame, ignored
      queue_req(OP_RELEASE, 20'd65535);
      queue_req(OP_ALLOC, 20'd0);          // grants the top frame
      queue_req(OP_FREE, 20'd65535);
      queue_req(OP_FREE, 20'd65536);
      queue_req(OP_RESERVE, 20'd65535);
      queue_req(OP_RESERVE, 20'hFFFFF);
      queue_req(OP_RELEASE, 20'h10000);
      queue_req(OP_RELEASE, 20'd5);
      queue_req(OP_RELEASE, 20'd70);
      queue_req(OP_ALLOC_LOW, 20'd0);
      queue_req(OP_TEST, 20'd5);
      queue_req(OP_FREE, 20'd70);
      queue_req(OP_SPARE_A, 20'd70);
      queue_req(OP_SPARE_B, 20'hFFFFF);
      queue_req(OP_ALLOC, 20'd0);
      queue_req(OP_TEST, 20'd70);
      wait_drained();

      // Random phases: idle, stall, frames, low limit, skip window, items, frame span
      run_phase( 0,  0,   256,   200,    16,    80, 300,  300);
      run_phase(75,  0,    64, 65536,     0,     0, 250,  100);
      run_phase( 0, 75,  1024,   300,    40,    20, 300, 1100);  // inverted window
      run_phase( 7,  7,     0,     0, 65536, 65536, 150,   64);
      run_phase( 7,  7, 65536,  4096,     0,  4096, 120, 6000);  // window covers the limit
      run_phase(75,  0,   130, 65536,    64,   128, 250,  160);
      run_phase( 0,  0, 65536, 65536,   100, 65536, 200,  400);
      run_phase( 0, 75,     1,     1,     0,     1, 200,   40);
      run_phase( 7,  7,  4097, 65535,  4000,  4100, 250, 4200);

      repeat (20) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d response items never arrived", expected_rsp.size()));

      $display("Checked %0d response items for %0d requests over %0d register settings",
               rsp_count, accepted_count, phase_count + 1);
      $display("Allocator granted %0d frames and refused %0d allocations; %0d mismatches",
               grant_count, refused_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("frame_bitmap_allocator_top verification clean");
      end else begin
         $display("frame_bitmap_allocator_top verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400_000_000;
      $display("Timeout with %0d requests queued and %0d response items owed",
               req_queue.size(), expected_rsp.size());
      $display("frame_bitmap_allocator_top verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fba_pkg.sv
hw/rtl/fba_word_ram.sv
hw/rtl/frame_bitmap_allocator_top.sv
test/tb_top.sv
